// File: hw/rtl/lmo_pkg.sv
// Shared types, widths, register indexes and reset values for the lane FIFO
// occupancy model. Used by every RTL file of the block but lmo_ram; depends on nothing.
package lmo_pkg;

    // Field widths fixed by the interface.
    localparam int COL_W      = 9;
    localparam int TIME_W     = 48;
    localparam int NRG_W      = 16;
    localparam int WORD_W     = 64;
    localparam int OUTC_W     = 2;
    localparam int LANE_OUT_W = 4;
    localparam int FILL_W     = 16;
    localparam int PERIOD_W   = 24;
    localparam int LCNT_W     = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_READ_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT  = 2'd2;

    localparam logic [PERIOD_W-1:0] READ_PERIOD_RST = 24'd6400;
    localparam logic [FILL_W-1:0]   FILL_LIMIT_RST  = 16'd16;
    localparam logic [LCNT_W-1:0]   LANE_COUNT_RST  = 5'd1;

    // Parameter defaults and limits.
    localparam int MAX_LANES_DEF = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int LANE_MAX_W    = 6;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [OUTC_W-1:0] {
        OUT_STORED  = 2'd0,
        OUT_DROPPED = 2'd1,
        OUT_BELOW   = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MOD,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_START,
        BK_DIV,
        BK_UPD,
        BK_OUT
    } back_state_t;

    // A classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic                  below;
        logic [LANE_MAX_W-1:0] lane;
        logic [TIME_W-1:0]     hit_time;
        logic [WORD_W-1:0]     hit_word;
    } hit_cls_t;

endpackage

// File: hw/rtl/lmo_ifs.sv
// Handshake interfaces for the hit request channel and the result channel.
// Depends on lmo_pkg for the field widths.
interface lmo_hit_if;
    logic                          valid;
    logic                          ready;
    logic [lmo_pkg::COL_W-1:0]     hit_column;
    logic [lmo_pkg::TIME_W-1:0]    hit_time;
    logic [lmo_pkg::NRG_W-1:0]     hit_energy;
    logic [lmo_pkg::NRG_W-1:0]     pixel_threshold;
    logic [lmo_pkg::WORD_W-1:0]    hit_word;

    modport source (
        output valid, hit_column, hit_time, hit_energy, pixel_threshold, hit_word,
        input  ready
    );
    modport sink (
        input  valid, hit_column, hit_time, hit_energy, pixel_threshold, hit_word,
        output ready
    );
endinterface

interface lmo_res_if;
    logic                           valid;
    logic                           ready;
    logic [lmo_pkg::OUTC_W-1:0]     outcome;
    logic [lmo_pkg::LANE_OUT_W-1:0] out_lane;
    logic [lmo_pkg::WORD_W-1:0]     out_word;
    logic [lmo_pkg::TIME_W-1:0]     out_time;
    logic [lmo_pkg::FILL_W-1:0]     lane_fill;

    modport source (
        output valid, outcome, out_lane, out_word, out_time, lane_fill,
        input  ready
    );
    modport sink (
        input  valid, outcome, out_lane, out_word, out_time, lane_fill,
        output ready
    );
endinterface

// File: hw/rtl/lmo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lmo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/lmo_front.sv
// Front end: accepts hit requests, checks the threshold and maps the column
// to a lane with a bit-serial remainder. Depends on lmo_pkg and lmo_ifs.
module lmo_front #(
    parameter int MAX_LANES = lmo_pkg::MAX_LANES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    lmo_hit_if.sink                              hit,
    input  logic [$clog2(2 * MAX_LANES)-1:0]     eff_lanes,
    input  logic                                 q_full,
    output logic                                 q_push,
    output lmo_pkg::hit_cls_t                    q_entry
);
    localparam int MW    = $clog2(2 * MAX_LANES);
    localparam int CNT_W = $clog2(lmo_pkg::COL_W + 1);

    lmo_pkg::front_state_t       state_reg, state_next;
    logic [lmo_pkg::COL_W-1:0]   col_reg, col_next;
    logic [MW-1:0]               rem_reg, rem_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        below_reg, below_next;
    logic [lmo_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [lmo_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [MW:0]                 trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmo_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        below_reg <= below_next;
        time_reg  <= time_next;
        word_reg  <= word_next;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        below_next = below_reg;
        time_next  = time_reg;
        word_next  = word_reg;
        hit.ready  = 1'b0;
        q_push     = 1'b0;
        trial      = {rem_reg, col_reg[lmo_pkg::COL_W-1]};

        case (state_reg)
            lmo_pkg::FR_IDLE:
            begin
                hit.ready = 1'b1;
                if (hit.valid)
                begin
                    col_next   = hit.hit_column;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(lmo_pkg::COL_W);
                    below_next = (hit.hit_energy < hit.pixel_threshold);
                    time_next  = hit.hit_time;
                    word_next  = hit.hit_word;
                    state_next = lmo_pkg::FR_MOD;
                end
            end
            lmo_pkg::FR_MOD:
            begin
                // One column bit per cycle into the running remainder.
                if (trial >= {1'b0, eff_lanes})
                begin
                    rem_next = MW'(trial - {1'b0, eff_lanes});
                end
                else
                begin
                    rem_next = MW'(trial);
                end
                col_next = {col_reg[lmo_pkg::COL_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = lmo_pkg::FR_PUSH;
                end
            end
            lmo_pkg::FR_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = lmo_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = lmo_pkg::FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_entry.below    = below_reg;
        q_entry.lane     = lmo_pkg::LANE_MAX_W'(rem_reg);
        q_entry.hit_time = time_reg;
        q_entry.hit_word = word_reg;
    end
endmodule

// File: hw/rtl/lmo_queue.sv
// Short FIFO of classified requests between the front and back ends.
// Depends on lmo_pkg for the entry type.
module lmo_queue #(
    parameter int DEPTH = lmo_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lmo_pkg::hit_cls_t push_entry,
    input  logic              pop,
    output lmo_pkg::hit_cls_t head,
    output logic              full,
    output logic              empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lmo_pkg::hit_cls_t slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
endmodule

// File: hw/rtl/lmo_div.sv
// Radix-4 restoring divider: two quotient bits per cycle.
// Depends on lmo_pkg for the divisor width.
module lmo_div #(
    parameter int DW = 49
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DW-1:0]                 dividend,
    input  logic [lmo_pkg::PERIOD_W-1:0]  divisor,
    output logic                          done,
    output logic [DW-1:0]                 quotient,
    output logic [lmo_pkg::PERIOD_W-1:0]  remainder
);
    localparam int NDIG = (DW + 1) / 2;
    localparam int PW   = 2 * NDIG;
    localparam int CW   = $clog2(NDIG + 1);
    localparam int RW   = lmo_pkg::PERIOD_W;

    logic [PW-1:0]   num_reg, num_next;
    logic [PW-1:0]   quo_reg, quo_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   d_reg, d_next;
    logic [RW+1:0]   d3_reg, d3_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW+1:0]   x;
    logic [RW+1:0]   d1;
    logic [RW+1:0]   d2;
    logic [RW+1:0]   sub;
    logic [1:0]      digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        d3_reg  <= d3_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        d3_next   = d3_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x         = {rem_reg, num_reg[PW-1:PW-2]};
        d1        = {2'b00, d_reg};
        d2        = {1'b0, d_reg, 1'b0};
        sub       = '0;
        digit     = 2'd0;

        if (x >= d3_reg)
        begin
            digit = 2'd3;
            sub   = d3_reg;
        end
        else if (x >= d2)
        begin
            digit = 2'd2;
            sub   = d2;
        end
        else if (x >= d1)
        begin
            digit = 2'd1;
            sub   = d1;
        end

        if (start)
        begin
            num_next  = PW'(dividend);
            quo_next  = '0;
            rem_next  = '0;
            d_next    = divisor;
            d3_next   = {2'b00, divisor} + {1'b0, divisor, 1'b0};
            cnt_next  = CW'(NDIG);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = RW'(x - sub);
            num_next = {num_reg[PW-3:0], 2'b00};
            quo_next = {quo_reg[PW-3:0], digit};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg[DW-1:0];
    assign remainder = rem_reg;
endmodule

// File: hw/rtl/lmo_back.sv
// Back end: per-lane leaky-bucket update and the result register.
// Depends on lmo_pkg, lmo_ifs, lmo_ram and lmo_div.
module lmo_back #(
    parameter int MAX_LANES = lmo_pkg::MAX_LANES_DEF,
    parameter int TIME_BITS = lmo_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lmo_pkg::hit_cls_t             q_head,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [lmo_pkg::PERIOD_W-1:0]  period,
    input  logic [lmo_pkg::FILL_W-1:0]    fill_limit,
    lmo_res_if.source                     result
);
    localparam int TW = (TIME_BITS < lmo_pkg::TIME_W) ? TIME_BITS : lmo_pkg::TIME_W;
    localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int FW = lmo_pkg::FILL_W;
    localparam int CRW = lmo_pkg::PERIOD_W;
    localparam int SW = FW + TW + CRW;

    lmo_pkg::back_state_t        state_reg, state_next;
    lmo_pkg::hit_cls_t           item_reg, item_next;
    logic [MAX_LANES-1:0]        lane_valid_reg, lane_valid_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic [TW-1:0]               diff_reg, diff_next;
    logic [FW-1:0]               fill_old_reg, fill_old_next;
    logic [CRW-1:0]              credit_old_reg, credit_old_next;
    lmo_pkg::outcome_t           st_outcome_reg, st_outcome_next;
    logic [FW-1:0]               st_fill_reg, st_fill_next;

    logic                        out_valid_reg, out_valid_next;
    lmo_pkg::outcome_t           out_outcome_reg, out_outcome_next;
    logic [lmo_pkg::LANE_OUT_W-1:0] out_lane_reg, out_lane_next;
    logic [lmo_pkg::WORD_W-1:0]  out_word_reg, out_word_next;
    logic [lmo_pkg::TIME_W-1:0]  out_time_reg, out_time_next;
    logic [FW-1:0]               out_fill_reg, out_fill_next;

    logic                        ram_we;
    logic                        ram_re;
    logic [LW-1:0]               ram_raddr;
    logic [SW-1:0]               ram_wdata;
    logic [SW-1:0]               ram_rdata;
    logic [SW-1:0]               cur_entry;
    logic [TW-1:0]               cur_last;
    logic [TW-1:0]               t_cur;
    logic [LW-1:0]               item_lane;

    logic                        div_start;
    logic                        div_done;
    logic [TW:0]                 div_quo;
    logic [CRW-1:0]              div_rem;
    logic [TW:0]                 dividend;
    logic [FW-1:0]               drained;
    logic [FW-1:0]               fill_new;
    logic                        load_out;

    lmo_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LANES)
    ) u_lane_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_lane),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lmo_div #(
        .DW (TW + 1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (period),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lmo_pkg::BK_IDLE;
            lane_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        rd_valid_reg    <= rd_valid_next;
        diff_reg        <= diff_next;
        fill_old_reg    <= fill_old_next;
        credit_old_reg  <= credit_old_next;
        st_outcome_reg  <= st_outcome_next;
        st_fill_reg     <= st_fill_next;
        out_outcome_reg <= out_outcome_next;
        out_lane_reg    <= out_lane_next;
        out_word_reg    <= out_word_next;
        out_time_reg    <= out_time_next;
        out_fill_reg    <= out_fill_next;
    end

    assign item_lane = item_reg.lane[LW-1:0];
    assign ram_raddr = q_head.lane[LW-1:0];
    assign t_cur     = item_reg.hit_time[TW-1:0];
    // A lane that has never been written reads as all zero.
    assign cur_entry = rd_valid_reg ? ram_rdata : '0;
    assign cur_last  = cur_entry[CRW +: TW];
    assign dividend  = (TW + 1)'(diff_reg) + (TW + 1)'(credit_old_reg);
    assign ram_wdata = {fill_new, t_cur, div_rem};

    always_comb
    begin
        if ((|div_quo[TW:FW]) || (div_quo[FW-1:0] >= fill_old_reg))
        begin
            drained = '0;
        end
        else
        begin
            drained = fill_old_reg - div_quo[FW-1:0];
        end
        fill_new = (drained < fill_limit) ? drained + FW'(1) : drained;
    end

    assign load_out = (state_reg == lmo_pkg::BK_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        lane_valid_next = lane_valid_reg;
        rd_valid_next   = rd_valid_reg;
        diff_next       = diff_reg;
        fill_old_next   = fill_old_reg;
        credit_old_next = credit_old_reg;
        st_outcome_next = st_outcome_reg;
        st_fill_next    = st_fill_reg;
        q_pop           = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            lmo_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    item_next     = q_head;
                    ram_re        = 1'b1;
                    rd_valid_next = lane_valid_reg[ram_raddr];
                    if (q_head.below)
                    begin
                        st_outcome_next = lmo_pkg::OUT_BELOW;
                        st_fill_next    = '0;
                        state_next      = lmo_pkg::BK_OUT;
                    end
                    else
                    begin
                        state_next = lmo_pkg::BK_READ;
                    end
                end
            end
            lmo_pkg::BK_READ:
            begin
                // Time going backwards counts as no elapsed time.
                diff_next       = (t_cur >= cur_last) ? t_cur - cur_last : '0;
                fill_old_next   = cur_entry[CRW + TW +: FW];
                credit_old_next = cur_entry[CRW-1:0];
                state_next      = lmo_pkg::BK_START;
            end
            lmo_pkg::BK_START:
            begin
                div_start  = 1'b1;
                state_next = lmo_pkg::BK_DIV;
            end
            lmo_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = lmo_pkg::BK_UPD;
                end
            end
            lmo_pkg::BK_UPD:
            begin
                ram_we                     = 1'b1;
                lane_valid_next[item_lane] = 1'b1;
                st_fill_next               = fill_new;
                st_outcome_next = (drained < fill_limit) ? lmo_pkg::OUT_STORED
                                                         : lmo_pkg::OUT_DROPPED;
                state_next                 = lmo_pkg::BK_OUT;
            end
            lmo_pkg::BK_OUT:
            begin
                if (load_out)
                begin
                    state_next = lmo_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lmo_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && !result.ready;
        out_outcome_next = out_outcome_reg;
        out_lane_next    = out_lane_reg;
        out_word_next    = out_word_reg;
        out_time_next    = out_time_reg;
        out_fill_next    = out_fill_reg;
        if (load_out)
        begin
            out_valid_next   = 1'b1;
            out_outcome_next = st_outcome_reg;
            out_lane_next    = lmo_pkg::LANE_OUT_W'(item_reg.lane);
            out_word_next    = item_reg.hit_word;
            out_time_next    = item_reg.hit_time;
            out_fill_next    = st_fill_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.outcome   = out_outcome_reg;
    assign result.out_lane  = out_lane_reg;
    assign result.out_word  = out_word_reg;
    assign result.out_time  = out_time_reg;
    assign result.lane_fill = out_fill_reg;
endmodule

// File: hw/rtl/lane_fifo_occupancy_model.sv
// A hit below threshold goes from the queue straight to the result register of the back end;
// any other hit holds the back end through the lane read, the radix-4 divider and the write-back.
// The front end takes a new request only after pushing the last one into the queue,
// and a two-entry queue lets it work on the next request while the back end is busy.
// Reset (rst_n, asynchronous, active low) restores the register defaults and marks every
// lane empty at once through per-lane valid bits; no clearing pass is needed.
//
// Top level of the lane FIFO occupancy model: configuration registers, front end,
// request queue and back end. Depends on lmo_pkg, lmo_ifs and the lmo_* modules but lmo_checker.
module lane_fifo_occupancy_model #(
    parameter int MAX_LANES = lmo_pkg::MAX_LANES_DEF,
    parameter int TIME_BITS = lmo_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lmo_hit_if.sink                         hit,
    lmo_res_if.source                       result,
    input  logic                            cfg_we,
    input  logic [lmo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    // Width of the lane count and of the lane remainder in the front end.
    localparam int MW = $clog2(2 * MAX_LANES);

    logic [lmo_pkg::PERIOD_W-1:0] read_period_reg;
    logic [lmo_pkg::FILL_W-1:0]   fill_limit_reg;
    logic [lmo_pkg::LCNT_W-1:0]   lane_count_reg;

    logic [lmo_pkg::PERIOD_W-1:0] eff_period;
    logic [MW-1:0]                eff_lanes;

    logic                         q_push;
    logic                         q_pop;
    logic                         q_full;
    logic                         q_empty;
    lmo_pkg::hit_cls_t            q_in;
    lmo_pkg::hit_cls_t            q_head;

    // Configuration registers, written by the user only while the block is idle (the block
    // does not enforce this); both ends read them directly. Indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_period_reg <= lmo_pkg::READ_PERIOD_RST;
            fill_limit_reg  <= lmo_pkg::FILL_LIMIT_RST;
            lane_count_reg  <= lmo_pkg::LANE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmo_pkg::REG_READ_PERIOD: read_period_reg <= cfg_data;
                lmo_pkg::REG_FILL_LIMIT:  fill_limit_reg  <= cfg_data[lmo_pkg::FILL_W-1:0];
                lmo_pkg::REG_LANE_COUNT:  lane_count_reg  <= cfg_data[lmo_pkg::LCNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A zero read period behaves as one, and the lane count is clamped to
    // the range from one to the number of lanes built.
    assign eff_period = (read_period_reg == '0) ? lmo_pkg::PERIOD_W'(1) : read_period_reg;

    always_comb
    begin
        if (lane_count_reg == '0)
        begin
            eff_lanes = MW'(1);
        end
        else if (int'(lane_count_reg) > MAX_LANES)
        begin
            eff_lanes = MW'(MAX_LANES);
        end
        else
        begin
            eff_lanes = MW'(lane_count_reg);
        end
    end

    // The front end classifies each request (threshold, lane) and hands it on.
    lmo_front #(
        .MAX_LANES (MAX_LANES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit       (hit),
        .eff_lanes (eff_lanes),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // The queue lets the front end take the next request while the back end
    // is still dividing.
    lmo_queue #(
        .DEPTH (lmo_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // The back end drains the lane by whole read periods, decides store or drop, writes the lane
    // state back and presents the result; a hit below threshold goes straight to the result.
    lmo_back #(
        .MAX_LANES (MAX_LANES),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .period     (eff_period),
        .fill_limit (fill_limit_reg),
        .result     (result)
    );
endmodule

// File: hw/rtl/lmo_checker.sv
// Port-level checks on the result channel of the lane FIFO occupancy model,
// bound to the top level. Depends on lmo_pkg and lane_fifo_occupancy_model.
module lmo_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [lmo_pkg::OUTC_W-1:0]    res_outcome,
    input logic [lmo_pkg::FILL_W-1:0]    res_fill,
    input logic [lmo_pkg::WORD_W-1:0]    res_word
);
    // A below-threshold hit reports an empty lane fill.
    a_below_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_outcome == lmo_pkg::OUT_BELOW)) |-> (res_fill == '0))
        else $error("below-threshold result with nonzero lane fill");

    // A stored hit leaves at least one word in its lane.
    a_stored_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_outcome == lmo_pkg::OUT_STORED)) |-> (res_fill != '0))
        else $error("stored result with empty lane");

    // A stalled result stays offered with the same word.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_word)))
        else $error("result changed or withdrawn while stalled");
endmodule

bind lane_fifo_occupancy_model lmo_checker u_lmo_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_outcome (result.outcome),
    .res_fill    (result.lane_fill),
    .res_word    (result.out_word)
);

// File: dv/tb_top.sv
// Self-checking testbench for the lane FIFO occupancy model: drives hit requests,
// predicts every result from a per-lane leaky-bucket model and compares field by field.
// Depends on lmo_pkg, lmo_ifs and the lane_fifo_occupancy_model RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lmo_pkg::*;

    localparam int MAX_LANES     = MAX_LANES_DEF;
    localparam int RAND_PHASES   = 8;
    localparam int HITS_PER_PHASE = 175;
    localparam int LONG_HOLD     = 300;  // cycles the result side refuses to take anything
    localparam int DRAIN_CYCLES  = 60;   // quiet cycles after the last result has been checked, before the run ends
    localparam int MAX_REPORTS   = 50;

    // Index past the end of the register map; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One hit request as it is queued for the driver.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [TIME_W-1:0] stamp;
        logic [NRG_W-1:0]  energy;
        logic [NRG_W-1:0]  thresh;
        logic [WORD_W-1:0] word;
    } hit_req_t;

    // What the block is expected to report for one request.
    typedef struct packed {
        outcome_t              outcome;
        logic [LANE_OUT_W-1:0] lane;
        logic [WORD_W-1:0]     word;
        logic [TIME_W-1:0]     stamp;
        logic [FILL_W-1:0]     fill;
    } lane_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Clock: 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Everything the testbench drives starts at a known value.
    logic                  hit_valid = 1'b0;
    logic [COL_W-1:0]      hit_col = '0;
    logic [TIME_W-1:0]     hit_stamp = '0;
    logic [NRG_W-1:0]      hit_energy = '0;
    logic [NRG_W-1:0]      hit_thresh = '0;
    logic [WORD_W-1:0]     hit_word = '0;
    logic                  res_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lmo_hit_if hit_ch();
    lmo_res_if res_ch();

    assign hit_ch.valid           = hit_valid;
    assign hit_ch.hit_column      = hit_col;
    assign hit_ch.hit_time        = hit_stamp;
    assign hit_ch.hit_energy      = hit_energy;
    assign hit_ch.pixel_threshold = hit_thresh;
    assign hit_ch.hit_word        = hit_word;
    assign res_ch.ready           = res_ready;

    lane_fifo_occupancy_model uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit       (hit_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the configuration registers, updated when a write is issued.
    // Writes only happen while nothing is in flight, so the mirror never races a request.
    logic [PERIOD_W-1:0] read_period_reg = READ_PERIOD_RST;
    logic [FILL_W-1:0]   fill_limit_reg  = FILL_LIMIT_RST;
    logic [LCNT_W-1:0]   lane_cnt_reg    = LANE_COUNT_RST;

    // Per-lane occupancy state of the predictor; all lanes start empty at reset.
    logic [FILL_W-1:0] lane_fill_lvl [MAX_LANES];
    logic [TIME_W-1:0] lane_last     [MAX_LANES];
    logic [TIME_W-1:0] lane_credit   [MAX_LANES];

    initial
    begin
        for (int i = 0; i < MAX_LANES; i++)
        begin
            lane_fill_lvl[i] = '0;
            lane_last[i]     = '0;
            lane_credit[i]   = '0;
        end
    end

    hit_req_t     hit_backlog[$];       // requests waiting for the driver
    lane_result_t expected_results[$];  // predictions waiting for the block's results

    logic hit_taken = 1'b0;   // the request on the bus was accepted at the last rising edge
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;    // toggled by the stimulus to ask for one long result hold-off
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    int error_count = 0;
    int hits_accepted = 0;
    int results_seen = 0;
    int stored_cnt = 0;
    int dropped_cnt = 0;
    int below_cnt = 0;
    int reg_writes = 0;
    logic [TIME_W-1:0] t_now = '0;

    // Lane count as the block uses it: zero acts as one, anything above the lane
    // array size is clamped to it.
    function automatic int unsigned eff_lane_count();
        if (lane_cnt_reg == 0)
            return 1;
        if (lane_cnt_reg > MAX_LANES)
            return MAX_LANES;
        return lane_cnt_reg;
    endfunction

    // Leaky-bucket step for one accepted request. A request below its threshold is
    // reported against its lane but touches no state. Otherwise the elapsed time
    // (never negative) is added to the lane's credit, every whole read period in
    // the credit drains one word, and the request is stored only if the drained
    // fill level is still under the limit.
    function automatic lane_result_t predict_hit(hit_req_t h);
        lane_result_t      r;
        int unsigned       ln;
        longint unsigned   period;
        longint unsigned   elapsed;
        longint unsigned   total;
        longint unsigned   drains;
        longint unsigned   lvl;
        ln = h.col % eff_lane_count();
        period = (read_period_reg == 0) ? 1 : read_period_reg;
        r.lane  = ln[LANE_OUT_W-1:0];
        r.word  = h.word;
        r.stamp = h.stamp;
        if (h.energy < h.thresh)
        begin
            r.outcome = OUT_BELOW;
            r.fill    = '0;
            return r;
        end
        elapsed = (h.stamp >= lane_last[ln]) ? h.stamp - lane_last[ln] : 0;
        total   = elapsed + lane_credit[ln];
        drains  = total / period;
        lane_credit[ln] = TIME_W'(total % period);
        lvl = lane_fill_lvl[ln];
        lvl = (lvl > drains) ? lvl - drains : 0;
        if (lvl < fill_limit_reg)
        begin
            lvl = lvl + 1;
            r.outcome = OUT_STORED;
        end
        else
            r.outcome = OUT_DROPPED;
        lane_fill_lvl[ln] = lvl[FILL_W-1:0];
        lane_last[ln]     = h.stamp;
        r.fill = lvl[FILL_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Request driver. A new request is offered only once the previous one has been
    // accepted, so valid never drops while a request is pending. The idle roll is
    // taken per offer slot, which spreads the gaps over every phase of the block's work.
    always @(negedge clk)
    begin
        hit_req_t nxt;
        logic     offer;
        if (!rst_n)
            hit_valid <= 1'b0;
        else if (!hit_valid || hit_taken)
        begin
            offer = (hit_backlog.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer)
            begin
                nxt = hit_backlog.pop_front();
                hit_col    <= nxt.col;
                hit_stamp  <= nxt.stamp;
                hit_energy <= nxt.energy;
                hit_thresh <= nxt.thresh;
                hit_word   <= nxt.word;
            end
            hit_valid <= offer;
        end
    end

    // Result-side ready. Besides the random stalls it can hold ready low for a long
    // stretch, counted here, so that the block backs up and refuses new requests.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: everything is sampled at the rising edge. Results are checked before
    // the new prediction is queued; a result can never belong to a request accepted
    // at the same edge.
    always @(posedge clk)
    begin
        hit_req_t     h;
        lane_result_t want;
        hit_taken <= hit_ch.valid && hit_ch.ready;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual outcome %0d lane %0d",
                                 $time, res_ch.outcome, res_ch.out_lane);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("outcome", want.outcome, res_ch.outcome);
                    check_field("out_lane", want.lane, res_ch.out_lane);
                    check_field("out_word", want.word, res_ch.out_word);
                    check_field("out_time", want.stamp, res_ch.out_time);
                    check_field("lane_fill", want.fill, res_ch.lane_fill);
                    case (want.outcome)
                        OUT_STORED:  stored_cnt++;
                        OUT_DROPPED: dropped_cnt++;
                        default:     below_cnt++;
                    endcase
                end
            end
            if (hit_ch.valid && hit_ch.ready)
            begin
                h.col    = hit_ch.hit_column;
                h.stamp  = hit_ch.hit_time;
                h.energy = hit_ch.hit_energy;
                h.thresh = hit_ch.pixel_threshold;
                h.word   = hit_ch.hit_word;
                expected_results.insert(expected_results.size(), predict_hit(h));
                hits_accepted++;
            end
        end
    end

    task automatic queue_hit(input logic [COL_W-1:0] col, input logic [TIME_W-1:0] stamp,
                             input logic [NRG_W-1:0] energy, input logic [NRG_W-1:0] thresh,
                             input logic [WORD_W-1:0] word);
        hit_req_t h;
        h.col    = col;
        h.stamp  = stamp;
        h.energy = energy;
        h.thresh = thresh;
        h.word   = word;
        hit_backlog.insert(hit_backlog.size(), h);
    endtask

    // Register write: one cycle with the enable high, issued at the falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_READ_PERIOD: read_period_reg = data[PERIOD_W-1:0];
            REG_FILL_LIMIT:  fill_limit_reg  = data[FILL_W-1:0];
            REG_LANE_COUNT:  lane_cnt_reg    = data[LCNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Blocks until every queued request has been accepted and every result checked.
    // Since each request yields exactly one result, the block is idle at that point.
    task automatic wait_idle();
        while (hit_backlog.size() != 0 || hit_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Random hits with time steps scaled to the read period and the lane count, so
    // that lanes both fill up to the limit and drain. Mostly time moves forward;
    // a few steps jump far ahead or go backwards.
    task automatic queue_random_hits(input int count);
        longint unsigned span;
        longint unsigned step;
        int              roll;
        logic [NRG_W-1:0] energy;
        logic [NRG_W-1:0] thresh;
        span = ((read_period_reg == 0) ? 1 : read_period_reg) / eff_lane_count();
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                step = 0;
            else if (roll < 65)
                step = 64'($urandom_range(0, 32'(span / 2)));
            else if (roll < 88)
                step = 64'($urandom_range(0, 32'(2 * span)));
            else if (roll < 95)
                step = 64'($urandom);
            else
                step = 0;
            if (roll >= 95)
                t_now = t_now - TIME_W'($urandom_range(0, 32'(2 * span)));
            else
                t_now = t_now + step[TIME_W-1:0];
            if ($urandom_range(99) < 85)
            begin
                energy = NRG_W'($urandom);
                thresh = NRG_W'($urandom_range(0, energy));
            end
            else
            begin
                thresh = NRG_W'($urandom);
                energy = NRG_W'($urandom_range(0, thresh));
            end
            queue_hit(COL_W'($urandom_range(0, 511)), t_now, energy, thresh,
                      {$urandom, $urandom});
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic [PERIOD_W-1:0] period_pick;
        logic [FILL_W-1:0]   limit_pick;
        logic [LCNT_W-1:0]   lanes_pick;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset configuration: threshold edges, field extremes,
        // a huge time jump that drains the lane, then time going backwards.
        queue_hit(9'd0, 48'd0, 16'd0, 16'd0, 64'd0);
        queue_hit(9'd511, 48'd100, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_hit(9'd5, 48'd200, 16'd0, 16'hFFFF, 64'hA5A5_A5A5_5A5A_5A5A);
        queue_hit(9'd1, 48'd201, 16'd1233, 16'd1234, 64'h0123_4567_89AB_CDEF);
        queue_hit(9'd300, 48'hFFFF_FFFF_FFFF, 16'd40000, 16'd100, 64'h8000_0000_0000_0001);
        queue_hit(9'd2, 48'd1000, 16'd10, 16'd5, 64'h5555_AAAA_5555_AAAA);
        wait_idle();

        // Zero read period acts as one, zero lane count as one lane; the upper data
        // bits of the narrow registers are garbage that must be ignored, as is the
        // write past the end of the register map.
        write_reg(REG_READ_PERIOD, 24'd0);
        write_reg(REG_FILL_LIMIT, {8'hFF, 16'd2});
        write_reg(REG_LANE_COUNT, {19'h7FFFF, 5'd0});
        write_reg(REG_UNUSED, 24'hFFFFFF);
        queue_hit(9'd7, 48'd1000, 16'd20, 16'd20, 64'd7);
        queue_hit(9'd7, 48'd1001, 16'd20, 16'd20, 64'd8);
        queue_hit(9'd7, 48'd1001, 16'd20, 16'd20, 64'd9);
        wait_idle();

        // A zero fill limit never stores anything.
        write_reg(REG_FILL_LIMIT, 24'd0);
        queue_hit(9'd9, 48'd1005, 16'd3, 16'd1, 64'd10);
        wait_idle();

        // Fill a lane to four, then lower the limit beneath that level: requests are
        // dropped until draining brings the level under the new limit.
        write_reg(REG_FILL_LIMIT, 24'd4);
        repeat (4) queue_hit(9'd4, 48'd1005, 16'd9, 16'd9, {$urandom, $urandom});
        wait_idle();
        write_reg(REG_FILL_LIMIT, 24'd1);
        queue_hit(9'd4, 48'd1005, 16'd9, 16'd9, 64'd11);
        queue_hit(9'd4, 48'd1007, 16'd9, 16'd9, 64'd12);
        queue_hit(9'd4, 48'd1009, 16'd9, 16'd9, 64'd13);
        wait_idle();

        // Largest period and limit; lane counts above the lane array are clamped.
        write_reg(REG_READ_PERIOD, 24'hFFFFFF);
        write_reg(REG_FILL_LIMIT, 24'hFFFF);
        write_reg(REG_LANE_COUNT, 24'd31);
        queue_hit(9'd15, 48'd2000, 16'd1, 16'd0, 64'd14);
        queue_hit(9'd16, 48'd2000, 16'd1, 16'd0, 64'd15);
        queue_hit(9'd511, 48'd2000, 16'd1, 16'd0, 64'd16);
        queue_hit(9'd17, 48'h0000_0100_0000, 16'd1, 16'd0, 64'd17);
        wait_idle();
        write_reg(REG_LANE_COUNT, 24'd17);
        queue_hit(9'd31, 48'h0000_0100_0000, 16'd1, 16'd0, 64'd18);
        wait_idle();
        write_reg(REG_LANE_COUNT, 24'd3);
        queue_hit(9'd511, 48'h0000_0200_0000, 16'd1, 16'd0, 64'd19);
        t_now = 48'h0000_0200_0000;

        // Random phases, each under a fresh register setting and idle pattern. The
        // sender pauses between phases until every result has come back.
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_idle();
            case ($urandom_range(3))
                0:       period_pick = 24'd1;
                1:       period_pick = READ_PERIOD_RST;
                2:       period_pick = PERIOD_W'($urandom_range(1, 4096));
                default: period_pick = 24'hFFFFFF;
            endcase
            case ($urandom_range(3))
                0:       limit_pick = 16'd1;
                1:       limit_pick = FILL_W'($urandom_range(2, 8));
                2:       limit_pick = FILL_W'($urandom_range(1, 32));
                default: limit_pick = 16'hFFFF;
            endcase
            if ($urandom_range(1) == 0)
                lanes_pick = LCNT_W'($urandom_range(0, 31));
            else
                lanes_pick = ($urandom_range(1) == 0) ? 5'd1 : 5'd16;
            write_reg(REG_READ_PERIOD, period_pick);
            write_reg(REG_FILL_LIMIT, {8'($urandom_range(0, 255)), limit_pick});
            write_reg(REG_LANE_COUNT, {19'($urandom_range(0, 19'h7FFFF)), lanes_pick});
            if ($urandom_range(1) == 0)
                t_now = {16'($urandom_range(0, 16'hFFFF)), $urandom};
            @(posedge clk);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            queue_random_hits(HITS_PER_PHASE);
            // In the phases without idling, the result side also goes deaf for a long
            // stretch while the driver keeps offering, so the block fills and stalls.
            if (phase % 4 == 0)
                hold_req = ~hold_req;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d hit requests and %0d results over %0d register writes.",
                 hits_accepted, results_seen, reg_writes);
        $display("Outcomes seen: %0d stored, %0d dropped on a full lane, %0d below threshold.",
                 stored_cnt, dropped_cnt, below_cnt);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still outstanding.", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lmo_pkg.sv
hw/rtl/lmo_ifs.sv
hw/rtl/lmo_ram.sv
hw/rtl/lmo_front.sv
hw/rtl/lmo_queue.sv
hw/rtl/lmo_div.sv
hw/rtl/lmo_back.sv
hw/rtl/lane_fifo_occupancy_model.sv
hw/rtl/lmo_checker.sv
dv/tb_top.sv
